/* rtl/assert_macros.svh */
// assertion macros shared by the queue admission rtl
// depends on nothing; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BSQA_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication
`define BSQA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`else

`define BSQA_ASSERT_IMPL(label, clk, rst, lhs, rhs)
`define BSQA_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

/* rtl/bsqa_pkg.sv */
// shared types and constants for the bounded server queue admission unit
// depends on nothing
package bsqa_pkg;

  localparam int ARRIVAL_W           = 40;
  localparam int DURATION_W          = 30;
  localparam int TIME_W              = 48;
  localparam int LIMIT_W             = 6;
  localparam int DEFAULT_QUEUE_DEPTH = 64;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RETIRE
  } ctrl_state_t;

  // one result item
  typedef struct packed {
    logic              accepted;
    logic [TIME_W-1:0] finish;
  } result_t;

endpackage

/* rtl/bounded_server_queue_admission_unit.sv */
// channel      dir  payload                          accepted when
// in           in   arrival_time, service_duration   in_valid && in_ready
// out          out  accepted, finish_time            out_valid && out_ready
// cfg          in   cfg_write_data (buffer_limit)    cfg_write_en
//
// an item is taken in the idle state, then retires finished entries from the
// store, one per cycle through the store's registered read port, then decides.
// reset is synchronous; store contents are not cleared, only pointers, counts and other control state.
// a new item is taken while a result waits in the output register; the
// decision cycle holds until that register is free.
// top level: config register, output register, sequencer and finish time store
// uses bsqa_pkg, bsqa_ctrl, bsqa_store
module bounded_server_queue_admission_unit #(
  parameter int QUEUE_DEPTH = bsqa_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsqa_pkg::ARRIVAL_W-1:0]  arrival_time,
  input  logic [bsqa_pkg::DURATION_W-1:0] service_duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [bsqa_pkg::TIME_W-1:0]     finish_time,
  input  logic                          cfg_write_en,
  input  logic [bsqa_pkg::LIMIT_W-1:0]    cfg_write_data
);
  import bsqa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [LIMIT_W-1:0] buffer_limit;
  logic               out_free, res_valid;
  result_t            res;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr, rd_addr;
  logic [TIME_W-1:0]  wr_data, rd_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit <= '0;
    end else if (cfg_write_en) begin
      buffer_limit <= cfg_write_data;
    end
  end

  assign out_free = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      accepted <= res.accepted;
      finish_time <= res.finish;
    end
  end

  bsqa_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .arrival_time(arrival_time),
    .service_duration(service_duration),
    .buffer_limit(buffer_limit),
    .out_free(out_free),
    .res_valid(res_valid),
    .res(res),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bsqa_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

/* rtl/bsqa_store.sv */
// finish time store: one write port, one registered read port
// write-to-read forwarding on same address; uses bsqa_pkg
module bsqa_store #(
  parameter int  QUEUE_DEPTH = bsqa_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [PTR_W-1:0]          wr_addr,
  input  logic [bsqa_pkg::TIME_W-1:0] wr_data,
  input  logic [PTR_W-1:0]          rd_addr,
  output logic [bsqa_pkg::TIME_W-1:0] rd_data
);
  import bsqa_pkg::*;

  logic [TIME_W-1:0] mem [QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, new data wins on a collision
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/bsqa_ctrl.sv */
// admission sequencer: retires finished entries, decides and pushes
// uses bsqa_pkg, assert_macros.svh; drives the bsqa_store ports
module bsqa_ctrl #(
  parameter int  QUEUE_DEPTH = bsqa_pkg::DEFAULT_QUEUE_DEPTH,
  localparam int PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsqa_pkg::ARRIVAL_W-1:0]  arrival_time,
  input  logic [bsqa_pkg::DURATION_W-1:0] service_duration,
  input  logic [bsqa_pkg::LIMIT_W-1:0]    buffer_limit,
  input  logic                          out_free,
  output logic                          res_valid,
  output bsqa_pkg::result_t             res,
  output logic                          wr_en,
  output logic [PTR_W-1:0]              wr_addr,
  output logic [bsqa_pkg::TIME_W-1:0]     wr_data,
  output logic [PTR_W-1:0]              rd_addr,
  input  logic [bsqa_pkg::TIME_W-1:0]     rd_data
);
  import bsqa_pkg::*;
  `include "assert_macros.svh"

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  ctrl_state_t       state, state_next;
  logic [PTR_W-1:0]  head, head_next, tail;
  logic [OCC_W-1:0]  occupancy;
  logic [TIME_W-1:0] last_finish;
  logic [ARRIVAL_W-1:0] arrival;
  logic [TIME_W-1:0] cand;

  logic [TIME_W-1:0] start;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] cand_next;
  logic              pop, decide, admit, occ_ok;

  // candidate finish time, computed as the item is taken
  always_comb begin
    start = (last_finish > TIME_W'(arrival_time)) ? last_finish : TIME_W'(arrival_time);
    sum = {1'b0, start} + (TIME_W + 1)'(service_duration);
    cand_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  // retire and admission decisions
  always_comb begin
    occ_ok = (CMP_W'(occupancy) <= CMP_W'(buffer_limit)) &&
             (occupancy < OCC_W'(QUEUE_DEPTH));
    pop = (state == ST_RETIRE) && (occupancy != '0) && (rd_data <= TIME_W'(arrival));
    decide = (state == ST_RETIRE) && !pop && out_free;
    admit = decide && occ_ok;
    head_next = head;
    if (pop) begin
      head_next = (head == PTR_LAST) ? '0 : head + 1'b1;
    end
  end

  // store access: the read always tracks the next head
  assign rd_addr = head_next;
  assign wr_en   = admit;
  assign wr_addr = tail;
  assign wr_data = cand;

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    res_valid = 1'b0;
    res.accepted = admit;
    res.finish = admit ? cand : '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (decide) begin
          res_valid = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occupancy <= '0;
      last_finish <= '0;
    end else begin
      head <= head_next;
      if (pop) begin
        occupancy <= occupancy - 1'b1;
      end else if (admit) begin
        occupancy <= occupancy + 1'b1;
        tail <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
        last_finish <= cand;
      end
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      arrival <= arrival_time;
      cand <= cand_next;
    end
  end

  `BSQA_ASSERT_IMPL(a_occ_bound, clk, rst, 1'b1, occupancy <= OCC_W'(QUEUE_DEPTH))
  `BSQA_ASSERT_IMPL(a_ptr_match, clk, rst, 1'b1,
                    (head == tail) == ((occupancy == '0) || (occupancy == OCC_W'(QUEUE_DEPTH))))
  `BSQA_ASSERT_IMPL(a_finish_late, clk, rst, res_valid && res.accepted,
                    res.finish >= TIME_W'(arrival))
  `BSQA_ASSERT_NEXT(a_last_finish, clk, rst, res_valid && res.accepted,
                    last_finish == $past(res.finish))

endmodule

/* verif/tb.sv */
// self-checking testbench for bounded_server_queue_admission_unit
// scoreboard class predicts admission and finish time per request item
// depends on bsqa_pkg and the rtl of the unit, nothing else
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsqa_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  localparam logic [ARRIVAL_W-1:0]  ARRIVAL_MAX  = '1;
  localparam logic [DURATION_W-1:0] DURATION_MAX = '1;

  // predicts admission decisions and holds the outcomes still to come
  class admission_scoreboard;
    logic [TIME_W-1:0]  pending_finishes[$];
    logic [TIME_W-1:0]  latest_finish;
    logic [LIMIT_W-1:0] limit;
    result_t            expected_outcomes[$];
    int                 errors;
    int                 n_accepted;
    int                 n_rejected;

    function new();
      latest_finish = '0;
      limit         = '0;
      errors        = 0;
      n_accepted    = 0;
      n_rejected    = 0;
    endfunction

    function int outstanding();
      return expected_outcomes.size();
    endfunction

    // retire finished entries, then admit or drop the request
    function void admit_request(logic [ARRIVAL_W-1:0] arr, logic [DURATION_W-1:0] dur);
      logic [TIME_W-1:0] start;
      logic [TIME_W:0]   sum;
      result_t           r;
      while (pending_finishes.size() > 0 && pending_finishes[0] <= TIME_W'(arr))
        void'(pending_finishes.pop_front());
      if (pending_finishes.size() <= int'(limit) &&
          pending_finishes.size() < DEFAULT_QUEUE_DEPTH) begin
        start = (latest_finish > TIME_W'(arr)) ? latest_finish : TIME_W'(arr);
        sum   = {1'b0, start} + (TIME_W+1)'(dur);
        // clamp at the top of the time range
        latest_finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        pending_finishes.push_back(latest_finish);
        r.accepted = 1'b1;
        r.finish   = latest_finish;
      end else begin
        r.accepted = 1'b0;
        r.finish   = '0;
      end
      expected_outcomes.push_back(r);
    endfunction

    // compare one result item against the oldest prediction
    function void check_outcome(logic acc, logic [TIME_W-1:0] fin);
      result_t e;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result item accepted=%0d finish_time=%0d", $time, acc, fin);
        errors++;
        return;
      end
      e = expected_outcomes.pop_front();
      if (acc !== e.accepted) begin
        $display("%0t: accepted mismatch expected %0d actual %0d", $time, e.accepted, acc);
        errors++;
      end
      if (fin !== e.finish) begin
        $display("%0t: finish_time mismatch expected %0d actual %0d", $time, e.finish, fin);
        errors++;
      end
      if (e.accepted) n_accepted++;
      else n_rejected++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ARRIVAL_W-1:0]  arrival_time = '0;
  logic [DURATION_W-1:0] service_duration = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  accepted;
  logic [TIME_W-1:0]     finish_time;
  logic                  cfg_write_en = 1'b0;
  logic [LIMIT_W-1:0]    cfg_write_data = '0;

  admission_scoreboard   sb;
  logic [ARRIVAL_W-1:0]  arrival_base = '0;
  bit                    src_gaps = 1'b1;
  bit                    sink_stalls = 1'b1;
  int                    stall_left = 0;
  int                    cycle_count = 0;
  int                    limit_writes = 0;

  bounded_server_queue_admission_unit #(
    .QUEUE_DEPTH(DEFAULT_QUEUE_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .arrival_time    (arrival_time),
    .service_duration(service_duration),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .finish_time     (finish_time),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data)
  );

  always #10 clk = ~clk;

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_outcome(accepted, finish_time);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.outstanding());
      $display("bounded_server_queue_admission_unit regression: fail");
      $finish;
    end
  end

  // present one request item and hold it until taken
  task automatic send_item(input logic [ARRIVAL_W-1:0] arr, input logic [DURATION_W-1:0] dur);
    int idle;
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      idle = pick_gap();
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid         <= 1'b1;
    arrival_time     <= arr;
    service_duration <= dur;
    do @(posedge clk); while (!in_ready);
    sb.admit_request(arr, dur);
  endtask

  // drop valid and let every outstanding result drain
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  // write buffer_limit once the unit is idle
  task automatic set_buffer_limit(input logic [LIMIT_W-1:0] v);
    drain_results();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.limit = v;
    limit_writes++;
  endtask

  // random request: mostly advancing time, some backward steps and full drains
  task automatic send_random(input int gap_bits, input int dur_bits);
    int                    r;
    logic [ARRIVAL_W-1:0]  step;
    logic [ARRIVAL_W-1:0]  arr;
    logic [DURATION_W-1:0] dur;
    step = ARRIVAL_W'($urandom_range(0, (1 << gap_bits) - 1));
    r = $urandom_range(0, 99);
    if (r < 3) begin
      arr = (arrival_base > step) ? arrival_base - step : '0;
    end else begin
      // jump past every queued finish time
      if (r < 7 && sb.latest_finish > TIME_W'(arrival_base))
        arrival_base = sb.latest_finish[ARRIVAL_W-1:0];
      arrival_base = arrival_base + step;
      arr = arrival_base;
    end
    r = $urandom_range(0, 99);
    if (r < 2) dur = DURATION_W'($urandom());
    else if (r < 3) dur = DURATION_MAX;
    else dur = DURATION_W'($urandom_range(0, (1 << dur_bits) - 1));
    send_item(arr, dur);
  endtask

  initial begin
    logic [ARRIVAL_W-1:0] a;
    int                   gap_bits;
    int                   dur_bits;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero fields, max duration, retire on equal time, reject at limit 0
    send_item('0, '0);
    send_item('0, '0);
    send_item(ARRIVAL_W'(5), DURATION_MAX);
    send_item(ARRIVAL_W'(6), DURATION_W'(1));
    send_item(sb.latest_finish[ARRIVAL_W-1:0] - 1'b1, DURATION_W'(3));
    send_item(sb.latest_finish[ARRIVAL_W-1:0], DURATION_W'(7));

    // directed: fill past a small limit, backward arrival, then retire several at once
    set_buffer_limit(LIMIT_W'(3));
    a = sb.latest_finish[ARRIVAL_W-1:0] + ARRIVAL_W'(10);
    repeat (5) send_item(a, DURATION_W'(100));
    send_item('0, DURATION_W'(1));
    send_item(sb.latest_finish[ARRIVAL_W-1:0], '0);
    arrival_base = sb.latest_finish[ARRIVAL_W-1:0];

    // random phases over several limits and traffic shapes
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        set_buffer_limit('1);
        gap_bits = 2;
        dur_bits = 14;
      end else if (p == 1) begin
        set_buffer_limit('0);
        gap_bits = 10;
        dur_bits = 10;
      end else begin
        set_buffer_limit((p == 2) ? LIMIT_W'(1) : LIMIT_W'($urandom_range(0, 63)));
        gap_bits = $urandom_range(0, 20);
        dur_bits = gap_bits + $urandom_range(0, 4);
        if (dur_bits > 22) dur_bits = 22;
      end
      src_gaps    = (p % 3 != 0);
      sink_stalls = (p % 4 != 1);
      repeat (PHASE_ITEMS) send_random(gap_bits, dur_bits);
    end

    // closing: arrivals in the top half of the range, scattered, and the maximum
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    set_buffer_limit(LIMIT_W'($urandom_range(4, 63)));
    repeat (8) begin
      a = {1'b1, 7'($urandom()), 32'($urandom())};
      send_item(a, DURATION_W'($urandom()));
    end
    send_item(ARRIVAL_MAX, DURATION_MAX);
    send_item(ARRIVAL_MAX, '0);

    drain_results();
    repeat (80) @(posedge clk);
    $display("requests checked: %0d admitted, %0d dropped, %0d buffer limit settings",
             sb.n_accepted, sb.n_rejected, limit_writes);
    $display("mismatches: %0d, results still outstanding: %0d", sb.errors, sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("bounded_server_queue_admission_unit regression: pass");
    end else begin
      $display("bounded_server_queue_admission_unit regression: fail");
    end
    $finish;
  end

endmodule

/* bounded_server_queue_admission_unit.f */
+incdir+rtl
rtl/bsqa_pkg.sv
rtl/bsqa_store.sv
rtl/bsqa_ctrl.sv
rtl/bounded_server_queue_admission_unit.sv
verif/tb.sv
